>>> src/i2c_master_write_read_core_defines.svh
// assertion macros for the i2c master core
`ifndef I2C_MASTER_WRITE_READ_CORE_DEFINES_SVH
`define I2C_MASTER_WRITE_READ_CORE_DEFINES_SVH

// plain check, disabled during reset, clocked on aclk
`define I2CM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check that also runs during reset
`define I2CM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> src/i2cm_pkg.sv
// shared constants for the i2c master core
package i2cm_pkg;
    localparam int TX_DEPTH_DEF = 16;
    localparam int RX_MAX_DEF   = 255;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_BEGIN = 2'd1;
    localparam logic [1:0] MODE_PUSH  = 2'd2;

    localparam logic [1:0] CFG_BIT_PHASE  = 2'd0;
    localparam logic [1:0] CFG_SETUP_HOLD = 2'd1;
    localparam logic [1:0] CFG_ACK_POLL   = 2'd2;

    localparam logic [7:0] BIT_PHASE_RST  = 8'd2;
    localparam logic [7:0] SETUP_HOLD_RST = 8'd4;
    localparam logic [7:0] ACK_POLL_RST   = 8'd250;

    localparam logic [3:0] VOTE_HIGH_MIN = 4'd4;

    localparam logic [1:0] KIND_ADDR_W = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_ADDR_R = 2'd2;
endpackage

>>> src/i2c_master_write_read_core.sv
// i2c master running one combined write-then-read transaction per begin word
//
//  channel   signals                              role
//  s_        s_valid/s_ready + mode..tx_byte       command, push and tick words
//  m_        m_valid/m_ready + scl_level..count    one result word per input word
//  cfg_      cfg_wr_en/cfg_index/cfg_wdata         timing registers, write only
//
// The sequencer step sits between the input port and the result register, so a
// word is accepted in every cycle that the result register can take it.
// The result register frees the input side: s_ready is high whenever the
// result register is empty or is being taken in the same cycle.
// aresetn is synchronous, active low; the transmit FIFO has no clearing pass.
`include "i2c_master_write_read_core_defines.svh"
module i2c_master_write_read_core #(
    parameter int TX_DEPTH = i2cm_pkg::TX_DEPTH_DEF,
    parameter int RX_MAX   = i2cm_pkg::RX_MAX_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [3:0] s_sda_votes,
    input  logic [6:0] s_slave_addr,
    input  logic [4:0] s_write_count,
    input  logic [7:0] s_read_count,
    input  logic [7:0] s_tx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl_level,
    output logic       m_sda_level,
    output logic       m_busy_res,
    output logic       m_rx_valid,
    output logic [7:0] m_rx_byte,
    output logic       m_rx_last,
    output logic       m_done_res,
    output logic       m_ack_error,
    output logic [15:0] m_error_count
);
    import i2cm_pkg::*;

    localparam int PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int CNT_W = $clog2(TX_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_TX_LO, PH_TX_HI, PH_AK_LO,
        PH_AK_WAIT, PH_LOAD, PH_RX_LO, PH_RX_HI, PH_MA_LO, PH_MA_HI,
        PH_SP_A, PH_SP_B, PH_SP_C
    } phase_t;

    // configuration registers
    logic [7:0] bit_phase_reg, setup_hold_reg, ack_poll_reg;

    // sequencer state
    phase_t         phase_reg, phase_next;
    logic [7:0]     tick_reg, tick_next;
    logic [3:0]     bit_idx_reg, bit_idx_next;
    logic [7:0]     shift_reg, shift_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [4:0]     writes_reg, writes_next;
    logic [7:0]     reads_reg, reads_next;
    logic [6:0]     addr_reg, addr_next;
    logic [1:0]     kind_reg, kind_next;
    logic           scl_reg, scl_next, sda_reg, sda_next;
    logic           err_flag_reg, err_flag_next;
    logic [15:0]    err_cnt_reg, err_cnt_next;
    logic           rx_valid_next, rx_last_next, done_next;
    logic [7:0]     rx_byte_next;
    logic           m_valid_reg;

    // transmit fifo
    logic [7:0]       fifo_mem [TX_DEPTH];
    logic [7:0]       fifo_rd_reg;
    logic             fifo_wr;
    logic [PTR_W-1:0] fifo_wr_addr;
    logic [SUM_W-1:0] slot_sum;

    // timing helpers
    logic       in_fire, out_fire, line_high, over_bit, over_setup;
    logic [7:0] tc_inc, shift_in;
    logic [3:0] bit_inc;
    logic [7:0] rc_clamped;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid_reg && m_ready;
    assign s_ready  = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    assign line_high  = s_sda_votes >= VOTE_HIGH_MIN;
    assign tc_inc     = tick_reg + 8'd1;
    assign over_bit   = (tc_inc >= bit_phase_reg) || (tc_inc == 8'd0);
    assign over_setup = (tc_inc >= setup_hold_reg) || (tc_inc == 8'd0);
    assign shift_in   = {shift_reg[6:0], line_high};
    assign bit_inc    = bit_idx_reg + 4'd1;
    assign rc_clamped = ({9'd0, s_read_count} > 17'(RX_MAX)) ? 8'(RX_MAX) : s_read_count;

    // next free fifo slot, wrapped at the depth
    assign slot_sum     = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign fifo_wr_addr = (slot_sum >= SUM_W'(TX_DEPTH)) ?
                          PTR_W'(slot_sum - SUM_W'(TX_DEPTH)) : PTR_W'(slot_sum);
    assign fifo_wr      = in_fire && (s_mode == MODE_PUSH) &&
                          (count_reg < CNT_W'(TX_DEPTH));

    // sequencer step for one word
    always_comb begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_idx_next  = bit_idx_reg;
        shift_next    = shift_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        writes_next   = writes_reg;
        reads_next    = reads_reg;
        addr_next     = addr_reg;
        kind_next     = kind_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        err_flag_next = err_flag_reg;
        err_cnt_next  = err_cnt_reg;
        rx_valid_next = 1'b0;
        rx_byte_next  = 8'd0;
        rx_last_next  = 1'b0;
        done_next     = 1'b0;
        if (in_fire) begin
            unique case (s_mode)
                MODE_BEGIN: begin
                    if (phase_reg == PH_IDLE) begin
                        if (s_write_count == 5'd0) begin
                            done_next = 1'b1;
                        end else begin
                            addr_next   = s_slave_addr;
                            writes_next = s_write_count;
                            reads_next  = rc_clamped;
                            kind_next   = KIND_ADDR_W;
                            shift_next  = {s_slave_addr, 1'b0};
                            phase_next  = PH_ST_A;
                            tick_next   = 8'd0;
                        end
                    end
                end
                MODE_PUSH: begin
                    if (fifo_wr) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_TICK: begin
                    if (phase_reg != PH_IDLE) begin
                        // bus levels from the phase being left
                        unique case (phase_reg)
                            PH_ST_B:  begin scl_next = 1'b1; sda_next = 1'b0; end
                            PH_ST_C:  begin scl_next = 1'b0; sda_next = 1'b0; end
                            PH_TX_LO: begin scl_next = 1'b0; sda_next = shift_reg[7]; end
                            PH_TX_HI: begin scl_next = 1'b1; sda_next = shift_reg[7]; end
                            PH_AK_LO, PH_LOAD, PH_RX_LO: begin
                                scl_next = 1'b0; sda_next = 1'b1;
                            end
                            PH_MA_LO: begin scl_next = 1'b0; sda_next = !(reads_reg > 8'd1); end
                            PH_MA_HI: begin scl_next = 1'b1; sda_next = !(reads_reg > 8'd1); end
                            PH_SP_A:  begin scl_next = 1'b0; sda_next = 1'b0; end
                            PH_SP_B:  begin scl_next = 1'b1; sda_next = 1'b0; end
                            default:  begin scl_next = 1'b1; sda_next = 1'b1; end
                        endcase
                        // phase counters tick by default
                        tick_next = tc_inc;
                        unique case (phase_reg)
                            PH_ST_A: if (over_setup) begin
                                phase_next = PH_ST_B; tick_next = 8'd0;
                            end
                            PH_ST_B: if (over_setup) begin
                                phase_next = PH_ST_C; tick_next = 8'd0;
                            end
                            PH_ST_C: if (over_bit) begin
                                bit_idx_next = 4'd0; phase_next = PH_TX_LO; tick_next = 8'd0;
                            end
                            PH_TX_LO: if (over_bit) begin
                                phase_next = PH_TX_HI; tick_next = 8'd0;
                            end
                            PH_TX_HI: if (over_bit) begin
                                shift_next   = {shift_reg[6:0], 1'b0};
                                bit_idx_next = bit_inc;
                                phase_next   = (bit_inc >= 4'd8) ? PH_AK_LO : PH_TX_LO;
                                tick_next    = 8'd0;
                            end
                            PH_AK_LO: if (over_bit) begin
                                phase_next = PH_AK_WAIT; tick_next = 8'd0;
                            end
                            PH_AK_WAIT: begin
                                tick_next = 8'd0;
                                if (!line_high) begin
                                    if (kind_reg == KIND_ADDR_R) begin
                                        bit_idx_next = 4'd0;
                                        shift_next   = 8'd0;
                                        phase_next   = PH_RX_LO;
                                    end else if (writes_reg != 5'd0) begin
                                        phase_next = PH_LOAD;
                                    end else if (reads_reg != 8'd0) begin
                                        kind_next  = KIND_ADDR_R;
                                        shift_next = {addr_reg, 1'b1};
                                        phase_next = PH_ST_A;
                                    end else begin
                                        phase_next = PH_SP_A;
                                    end
                                end else if (tick_reg >= ack_poll_reg) begin
                                    // timeout: flag, count, stop and abort
                                    err_flag_next = 1'b1;
                                    if (err_cnt_reg != 16'hFFFF) begin
                                        err_cnt_next = err_cnt_reg + 16'd1;
                                    end
                                    writes_next = 5'd0;
                                    reads_next  = 8'd0;
                                    phase_next  = PH_SP_A;
                                end else begin
                                    tick_next = tc_inc;
                                end
                            end
                            PH_LOAD: begin
                                tick_next = tick_reg;
                                if (count_reg != CNT_W'(0)) begin
                                    shift_next   = fifo_rd_reg;
                                    head_next    = (head_reg == PTR_W'(TX_DEPTH - 1)) ?
                                                   PTR_W'(0) : head_reg + PTR_W'(1);
                                    count_next   = count_reg - CNT_W'(1);
                                    writes_next  = writes_reg - 5'd1;
                                    kind_next    = KIND_DATA;
                                    bit_idx_next = 4'd0;
                                    phase_next   = PH_TX_LO;
                                    tick_next    = 8'd0;
                                end
                            end
                            PH_RX_LO: if (over_bit) begin
                                phase_next = PH_RX_HI; tick_next = 8'd0;
                            end
                            PH_RX_HI: if (over_bit) begin
                                shift_next   = shift_in;
                                bit_idx_next = bit_inc;
                                tick_next    = 8'd0;
                                if (bit_inc >= 4'd8) begin
                                    rx_valid_next = 1'b1;
                                    rx_byte_next  = shift_in;
                                    rx_last_next  = reads_reg <= 8'd1;
                                    phase_next    = PH_MA_LO;
                                end else begin
                                    phase_next = PH_RX_LO;
                                end
                            end
                            PH_MA_LO: if (over_bit) begin
                                phase_next = PH_MA_HI; tick_next = 8'd0;
                            end
                            PH_MA_HI: if (over_bit) begin
                                tick_next = 8'd0;
                                if (reads_reg > 8'd1) begin
                                    reads_next   = reads_reg - 8'd1;
                                    bit_idx_next = 4'd0;
                                    shift_next   = 8'd0;
                                    phase_next   = PH_RX_LO;
                                end else begin
                                    reads_next = 8'd0;
                                    phase_next = PH_SP_A;
                                end
                            end
                            PH_SP_A: if (over_setup) begin
                                phase_next = PH_SP_B; tick_next = 8'd0;
                            end
                            PH_SP_B: if (over_setup) begin
                                phase_next = PH_SP_C; tick_next = 8'd0;
                            end
                            PH_SP_C: if (over_setup) begin
                                done_next = 1'b1; phase_next = PH_IDLE; tick_next = 8'd0;
                            end
                            default: begin
                                phase_next = PH_IDLE; tick_next = 8'd0;
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // fifo storage with a prefetched head word
    always_ff @(posedge aclk) begin
        if (fifo_wr) begin
            fifo_mem[fifo_wr_addr] <= s_tx_byte;
        end
        if (fifo_wr && (fifo_wr_addr == head_next)) begin
            fifo_rd_reg <= s_tx_byte;
        end else begin
            fifo_rd_reg <= fifo_mem[head_next];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_phase_reg  <= BIT_PHASE_RST;
            setup_hold_reg <= SETUP_HOLD_RST;
            ack_poll_reg   <= ACK_POLL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BIT_PHASE:  bit_phase_reg  <= cfg_wdata;
                CFG_SETUP_HOLD: setup_hold_reg <= cfg_wdata;
                CFG_ACK_POLL:   ack_poll_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= 8'd0;
            bit_idx_reg  <= 4'd0;
            shift_reg    <= 8'd0;
            head_reg     <= '0;
            count_reg    <= '0;
            writes_reg   <= 5'd0;
            reads_reg    <= 8'd0;
            addr_reg     <= 7'd0;
            kind_reg     <= KIND_ADDR_W;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            err_flag_reg <= 1'b0;
            err_cnt_reg  <= 16'd0;
        end else begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_idx_reg  <= bit_idx_next;
            shift_reg    <= shift_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            writes_reg   <= writes_next;
            reads_reg    <= reads_next;
            addr_reg     <= addr_next;
            kind_reg     <= kind_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            err_flag_reg <= err_flag_next;
            err_cnt_reg  <= err_cnt_next;
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (out_fire) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_scl_level   <= scl_next;
            m_sda_level   <= sda_next;
            m_busy_res    <= phase_next != PH_IDLE;
            m_rx_valid    <= rx_valid_next;
            m_rx_byte     <= rx_byte_next;
            m_rx_last     <= rx_last_next;
            m_done_res    <= done_next;
            m_ack_error   <= err_flag_next;
            m_error_count <= err_cnt_next;
        end
    end

    // checks
    `I2CM_ASSERT(a_rx_not_done, (m_valid_reg && m_rx_valid) |-> !m_done_res, "rx word marked done")
    `I2CM_ASSERT(a_err_consistent, err_flag_reg == (err_cnt_reg != 16'd0), "error flag and count disagree")
    `I2CM_ASSERT(a_fifo_bound, count_reg <= CNT_W'(TX_DEPTH), "fifo count above depth")
    `I2CM_ASSERT(a_idle_released, (phase_reg == PH_IDLE) |-> (scl_reg && sda_reg), "bus held while idle")
    `I2CM_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid_reg, "result word left after reset")
endmodule
